FILE: hdl/gf2_tagged_basis_engine_macros.svh
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - assertion macros
// Concurrent checks on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GF2_TAGGED_BASIS_ENGINE_MACROS_SVH
`define GF2_TAGGED_BASIS_ENGINE_MACROS_SVH

`ifndef SYNTH

// Check that the property holds at every clock edge out of reset.
`define GTBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the expression is never true out of reset.
`define GTBE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define GTBE_ASSERT(lbl, prop, msg)
`define GTBE_NEVER(lbl, expr, msg)

`endif

`endif

FILE: hdl/gtbe_pkg.sv
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - package
// Field widths, operation codes and the control group passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package gtbe_pkg;

  localparam int VectorBitsDef = 66;
  localparam int TagBitsDef    = 24;

  // Fixed port widths of the word fields
  localparam int VecLowW   = 64;
  localparam int VecHighW  = 2;
  localparam int TagPortW  = 24;
  localparam int CoordW    = 24;
  localparam int RankPortW = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // Control group that travels with a word from cell to cell
  typedef struct packed {
    logic valid;
    op_e  op;
    logic found;  // leading bit of the residue already seen
  } gtbe_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/gtbe_cell.sv
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - pivot cell
// Holds the basis row whose leading bit is POS, reduces the passing word by
// it and registers the result towards the next lower cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gtbe_cell
  import gtbe_pkg::*;
#(
  parameter int VEC_BITS = VectorBitsDef,
  parameter int TAG_BITS = TagBitsDef,
  parameter int POS      = 0,
  localparam int PosW    = $clog2(VEC_BITS)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  // word from the cell above
  input  wire gtbe_ctl_t           up_ctl_i,
  input  wire logic [VEC_BITS-1:0] up_vec_i,
  input  wire logic [TAG_BITS-1:0] up_acc_i,
  input  wire logic [PosW-1:0]     up_lead_i,
  // word to the cell below
  output gtbe_ctl_t                dn_ctl_o,
  output logic [VEC_BITS-1:0]      dn_vec_o,
  output logic [TAG_BITS-1:0]      dn_acc_o,
  output logic [PosW-1:0]          dn_lead_o,
  // write-back of a new row
  input  wire logic                wb_en_i,
  input  wire logic [PosW-1:0]     wb_lead_i,
  input  wire logic [VEC_BITS-1:0] wb_vec_i,
  input  wire logic [TAG_BITS-1:0] wb_tag_i,
  output logic                     occ_o
);

  logic                occ_q;
  logic [VEC_BITS-1:0] row_q;
  logic [TAG_BITS-1:0] tag_q;

  gtbe_ctl_t           ctl_q, ctl_d;
  logic [VEC_BITS-1:0] vec_q, vec_d;
  logic [TAG_BITS-1:0] acc_q, acc_d;
  logic [PosW-1:0]     lead_q, lead_d;
  logic                hit;
  logic                wb_here;

  assign hit     = occ_q & up_vec_i[POS];
  assign wb_here = wb_en_i && (wb_lead_i == PosW'(POS));

  always_comb begin
    vec_d  = hit ? (up_vec_i ^ row_q) : up_vec_i;
    acc_d  = hit ? (up_acc_i ^ tag_q) : up_acc_i;
    ctl_d  = up_ctl_i;
    lead_d = up_lead_i;
    // bits above POS are settled, so the first set bit seen is the lead
    if (!up_ctl_i.found && vec_d[POS]) begin
      ctl_d.found = 1'b1;
      lead_d      = PosW'(POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      occ_q <= 1'b0;
    end else begin
      if (advance_i) begin
        ctl_q <= ctl_d;
      end
      if (wb_here) begin
        occ_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      vec_q  <= vec_d;
      acc_q  <= acc_d;
      lead_q <= lead_d;
    end
    if (wb_here) begin
      row_q <= wb_vec_i;
      tag_q <= wb_tag_i;
    end
  end

  assign dn_ctl_o  = ctl_q;
  assign dn_vec_o  = vec_q;
  assign dn_acc_o  = acc_q;
  assign dn_lead_o = lead_q;
  assign occ_o     = occ_q;

endmodule

`default_nettype wire

FILE: hdl/gf2_tagged_basis_engine.sv
// An accepted word passes the register of every pivot cell and then the result
// register. The word walks the chain of pivot cells, one cell per cycle while the
// chain advances, and a new word enters only once the last one has left the chain.
// A waiting result holds the chain at its last cell until it is taken.
// Reset (rst_ni low, asynchronous) empties every basis row and clears rank.
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - top level
// Echelon basis over GF(2) with tagged rows; insert and coordinate query.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf2_tagged_basis_engine_macros.svh"

module gf2_tagged_basis_engine
  import gtbe_pkg::*;
#(
  parameter int VECTOR_BITS = VectorBitsDef,
  parameter int TAG_BITS    = TagBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [VecLowW-1:0]   vector_low_i,
  input  wire logic [VecHighW-1:0]  vector_high_i,
  input  wire logic [TagPortW-1:0]  tag_i,
  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      inserted_o,
  output logic                      in_span_o,
  output logic [CoordW-1:0]         coordinate_o,
  output logic [RankPortW-1:0]      rank_now_o
);

  localparam int PosW  = $clog2(VECTOR_BITS);
  localparam int RankW = $clog2(VECTOR_BITS + 1);

  // Chain links: element k+1 feeds cell k, element VECTOR_BITS is the head
  gtbe_ctl_t            ctl_chain  [0:VECTOR_BITS];
  logic [VECTOR_BITS-1:0] vec_chain [0:VECTOR_BITS];
  logic [TAG_BITS-1:0]  acc_chain  [0:VECTOR_BITS];
  logic [PosW-1:0]      lead_chain [0:VECTOR_BITS];
  logic [VECTOR_BITS-1:0] occ;

  logic                 busy_q;
  logic [RankW-1:0]     rank_q;
  logic                 out_valid_q;
  logic                 inserted_q;
  logic                 in_span_q;
  logic [CoordW-1:0]    coordinate_q;
  logic [RankPortW-1:0] rank_now_q;

  logic                 accept;
  logic                 out_free;
  logic                 advance;
  logic                 load;
  logic                 tail_insert;
  logic [RankW-1:0]     rank_next;
  logic [VecHighW+VecLowW+VECTOR_BITS-1:0] vec_wide;
  logic [TagPortW+TAG_BITS-1:0]            tag_wide;
  logic [CoordW+TAG_BITS-1:0]              coord_wide;
  logic [RankPortW+RankW-1:0]              rank_wide;
  gtbe_ctl_t            head_ctl;
  gtbe_ctl_t            tail_ctl;

  // Take one word at a time; the output register frees the chain early
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  // Hold the chain only while a finished word cannot leave the last cell
  assign advance  = !tail_ctl.valid || out_free;
  assign load     = tail_ctl.valid && out_free;

  // Build the head word: mask the vector and tag to their configured widths
  assign vec_wide = {{VECTOR_BITS{1'b0}}, vector_high_i, vector_low_i};
  assign tag_wide = {{TAG_BITS{1'b0}}, tag_i};

  always_comb begin
    head_ctl       = '0;
    head_ctl.valid = accept;
    head_ctl.op    = op_e'(operation_i);
    head_ctl.found = 1'b0;
  end

  assign ctl_chain[VECTOR_BITS]  = head_ctl;
  assign vec_chain[VECTOR_BITS]  = vec_wide[VECTOR_BITS-1:0];
  // a query starts from a clear tag, an insert from its own tag
  assign acc_chain[VECTOR_BITS]  = (op_e'(operation_i) == OP_QUERY) ?
                                   '0 : tag_wide[TAG_BITS-1:0];
  assign lead_chain[VECTOR_BITS] = '0;

  assign tail_ctl    = ctl_chain[0];
  // a residue with a leading bit is nonzero: store it at that bit
  assign tail_insert = (tail_ctl.op == OP_INSERT) && tail_ctl.found;
  assign rank_next   = rank_q + RankW'(tail_insert);
  assign coord_wide  = {{CoordW{1'b0}}, acc_chain[0]};
  assign rank_wide   = {{RankPortW{1'b0}}, rank_next};

  // Row of pivot cells, highest leading bit first
  for (genvar k = 0; k < VECTOR_BITS; k++) begin : g_cell
    gtbe_cell #(
      .VEC_BITS (VECTOR_BITS),
      .TAG_BITS (TAG_BITS),
      .POS      (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .up_ctl_i  (ctl_chain[k+1]),
      .up_vec_i  (vec_chain[k+1]),
      .up_acc_i  (acc_chain[k+1]),
      .up_lead_i (lead_chain[k+1]),
      .dn_ctl_o  (ctl_chain[k]),
      .dn_vec_o  (vec_chain[k]),
      .dn_acc_o  (acc_chain[k]),
      .dn_lead_o (lead_chain[k]),
      .wb_en_i   (load && tail_insert),
      .wb_lead_i (lead_chain[0]),
      .wb_vec_i  (vec_chain[0]),
      .wb_tag_i  (acc_chain[0]),
      .occ_o     (occ[k])
    );
  end

  // Control: busy flag, rank and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        rank_q      <= rank_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      inserted_q   <= tail_insert;
      in_span_q    <= !tail_ctl.found;
      coordinate_q <= (tail_ctl.op == OP_QUERY) ? coord_wide[CoordW-1:0] : '0;
      rank_now_q   <= rank_wide[RankPortW-1:0];
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign inserted_o   = inserted_q;
  assign in_span_o    = in_span_q;
  assign coordinate_o = coordinate_q;
  assign rank_now_o   = rank_now_q;

  // Occupied rows always match the rank count
  `GTBE_ASSERT(a_rank_matches_rows, $countones(occ) == int'(rank_q), "rank differs from rows")
  // Nothing travels the chain unless a word is in flight
  `GTBE_NEVER(a_idle_chain_empty, !busy_q && tail_ctl.valid, "word in chain while idle")
  // An accepted word keeps the engine busy on the next cycle
  `GTBE_ASSERT(a_accept_busy, accept |=> busy_q, "accepted word lost")
  // A stored row grows the rank by exactly one
  `GTBE_ASSERT(a_insert_rank, (load && tail_insert) |=> rank_q == $past(rank_q) + 1'b1,
               "rank did not grow on insert")

endmodule

`default_nettype wire

FILE: test/gf2_basis_result_checker.sv
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - result checker
// Watches both channels, predicts each result word and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gf2_basis_result_checker
  import gtbe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic                 operation_i,
  input  wire logic [VecLowW-1:0]   vector_low_i,
  input  wire logic [VecHighW-1:0]  vector_high_i,
  input  wire logic [TagPortW-1:0]  tag_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic                 inserted_i,
  input  wire logic                 in_span_i,
  input  wire logic [CoordW-1:0]    coordinate_i,
  input  wire logic [RankPortW-1:0] rank_now_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               awaited_count_o,
  output int unsigned               checked_count_o,
  output int unsigned               basis_rank_o
);

  localparam int NBits = VectorBitsDef;
  localparam int TagW  = TagBitsDef;

  typedef struct packed {
    logic                 inserted;
    logic                 in_span;
    logic [CoordW-1:0]    coordinate;
    logic [RankPortW-1:0] rank_now;
  } result_word_t;

  logic [NBits-1:0] basis_row [NBits];
  logic [TagW-1:0]  row_tag   [NBits];
  int unsigned      basis_rank;
  result_word_t     awaited_results [$];

  // Reduce from the top pivot down; store a nonzero insert residue at its leading bit.
  function automatic result_word_t reduce_against_basis(op_e op, logic [NBits-1:0] vec,
                                                        logic [TagW-1:0] tg);
    logic [NBits-1:0] residue;
    logic [TagW-1:0]  coord;
    result_word_t     res;
    int               lead;
    residue = vec;
    coord   = (op == OP_INSERT) ? tg : '0;
    lead    = -1;
    res     = '0;
    for (int p = NBits - 1; p >= 0; p--) begin
      if (basis_row[p] != '0 && residue[p]) begin
        residue ^= basis_row[p];
        coord   ^= row_tag[p];
      end
    end
    res.in_span = (residue == '0);
    if (op == OP_QUERY) begin
      res.coordinate = coord;
    end else if (residue != '0) begin
      for (int p = NBits - 1; p >= 0; p--) begin
        if (residue[p] && lead < 0) lead = p;
      end
      basis_row[lead] = residue;
      row_tag[lead]   = coord;
      basis_rank++;
      res.inserted = 1'b1;
    end
    res.rank_now = basis_rank[RankPortW-1:0];
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t want;
    if (!rst_ni) begin
      for (int p = 0; p < NBits; p++) begin
        basis_row[p] = '0;
        row_tag[p]   = '0;
      end
      basis_rank = 0;
      awaited_results.delete();
      mismatch_count_o <= 0;
      awaited_count_o  <= 0;
      checked_count_o  <= 0;
      basis_rank_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result word, inserted %0d in_span %0d coordinate %h rank %0d",
                   $time, inserted_i, in_span_i, coordinate_i, rank_now_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("inserted", want.inserted, inserted_i);
          check_field("in_span", want.in_span, in_span_i);
          check_field("coordinate", want.coordinate, coordinate_i);
          check_field("rank_now", want.rank_now, rank_now_i);
          checked_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results = {awaited_results, reduce_against_basis(op_e'(operation_i),
            {vector_high_i, vector_low_i}, tag_i)};
      end
      awaited_count_o <= awaited_results.size();
      basis_rank_o    <= basis_rank;
    end
  end

endmodule

FILE: test/gf2_tagged_basis_engine_tb.sv
// ----------------------------------------------------------------------------
// GF(2) tagged basis engine - testbench top
// Drives insert and query words through the engine under several idling
// patterns; a checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gf2_tagged_basis_engine_tb;
  import gtbe_pkg::*;

  localparam int VecW         = VecLowW + VecHighW;
  localparam int IdleBusyPct  = 64;       // heavy idling on one side
  localparam int IdleBothPct  = 17;       // light idling on both sides
  localparam int SegmentWords = 235;      // random words per idling segment
  localparam int SegmentCount = 8;
  localparam int MaskStep     = 28;       // random words between span growth steps
  localparam int HistoryDepth = 48;
  localparam int DrainCycles  = 80;       // idle clocks after the final drain
  localparam int CycleLimit   = 1_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 operation = OP_INSERT;
  logic [VecLowW-1:0]   vector_low = '0;
  logic [VecHighW-1:0]  vector_high = '0;
  logic [TagPortW-1:0]  tag = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 inserted;
  logic                 in_span;
  logic [CoordW-1:0]    coordinate;
  logic [RankPortW-1:0] rank_now;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned checked_count;
  int unsigned basis_rank;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned insert_words  = 0;
  int unsigned query_words   = 0;
  int unsigned cycle_count   = 0;

  // Vectors of recent inserts; any XOR of them lies in the span
  logic [VecW-1:0] insert_history [$];
  // Bits that random vectors may use; widened through the run so rank grows slowly
  logic [VecW-1:0] span_mask;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gf2_tagged_basis_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .vector_low_i  (vector_low),
    .vector_high_i (vector_high),
    .tag_i         (tag),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .inserted_o    (inserted),
    .in_span_o     (in_span),
    .coordinate_o  (coordinate),
    .rank_now_o    (rank_now)
  );

  gf2_basis_result_checker u_basis_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .operation_i      (operation),
    .vector_low_i     (vector_low),
    .vector_high_i    (vector_high),
    .tag_i            (tag),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .inserted_i       (inserted),
    .in_span_i        (in_span),
    .coordinate_i     (coordinate),
    .rank_now_i       (rank_now),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count),
    .checked_count_o  (checked_count),
    .basis_rank_o     (basis_rank)
  );

  // Stall the result channel at the rate of the current segment.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited",
               $time, cycle_count, awaited_count);
      $display("** gf2_tagged_basis_engine: FAILED **");
      $finish;
    end
  end

  // Idle at random, then hold the word until the engine takes it.
  task automatic send_word(op_e op, logic [VecW-1:0] vec, logic [TagPortW-1:0] tg);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    vector_low  <= vec[VecLowW-1:0];
    vector_high <= vec[VecW-1:VecLowW];
    tag         <= tg;
    do @(posedge clk); while (in_stall);
    if (op == OP_INSERT) begin
      insert_words++;
      insert_history = {insert_history, vec};
      if (insert_history.size() > HistoryDepth) void'(insert_history.pop_front());
    end else begin
      query_words++;
    end
  endtask

  // Drop valid and hold off until every awaited result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  function automatic logic [VecW-1:0] random_vector();
    logic [VecW-1:0] v;
    v[31:0]           = $urandom();
    v[63:32]          = $urandom();
    v[VecW-1:VecLowW] = VecHighW'($urandom_range(3));
    return v;
  endfunction

  // Random XOR of recent inserts: always reduces to zero.
  function automatic logic [VecW-1:0] span_combination();
    logic [VecW-1:0] v;
    v = '0;
    foreach (insert_history[i]) begin
      if ($urandom_range(1)) v ^= insert_history[i];
    end
    return v;
  endfunction

  // Mostly well-formed traffic inside the current span, with some noise.
  task automatic send_random_word();
    int unsigned         kind;
    logic [VecW-1:0]     v;
    logic [TagPortW-1:0] tg;
    kind = $urandom_range(99);
    tg   = TagPortW'($urandom());
    if (kind < 40) begin
      send_word(OP_INSERT, random_vector() & span_mask, tg);
    end else if (kind < 55) begin
      send_word(OP_INSERT, span_combination(), tg);
    end else if (kind < 80) begin
      send_word(OP_QUERY, span_combination(), tg);
    end else if (kind < 92) begin
      send_word(OP_QUERY, random_vector() & span_mask, tg);
    end else if (kind < 96) begin
      send_word(OP_QUERY, random_vector(), tg);
    end else begin
      // zero vector or a lone bit, either operation
      v = '0;
      if ($urandom_range(1)) v[$urandom_range(VecW - 1)] = 1'b1;
      send_word($urandom_range(1) ? OP_QUERY : OP_INSERT, v, tg);
    end
  endtask

  initial begin
    int unsigned b;
    span_mask = '0;
    span_mask[0] = 1'b1;
    span_mask[63] = 1'b1;
    span_mask[64] = 1'b1;
    span_mask[65] = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words, no idling: empty basis, extreme bits, duplicates, zero.
    send_word(OP_QUERY,  '0, 24'hFFFFFF);
    send_word(OP_QUERY,  '1, 24'h000000);
    send_word(OP_INSERT, '0, 24'hFFFFFF);
    send_word(OP_INSERT, {2'b10, 64'h0}, 24'h000001);
    send_word(OP_INSERT, {2'b01, 64'h0}, 24'h000002);
    send_word(OP_INSERT, {2'b00, 64'h8000_0000_0000_0000}, 24'h800000);
    send_word(OP_INSERT, {2'b00, 64'h1}, 24'hFFFFFF);
    send_word(OP_INSERT, '1, 24'hA5A5A5);
    send_word(OP_INSERT, {2'b10, 64'h1}, 24'h123456);
    send_word(OP_QUERY,  {2'b10, 64'h1}, 24'h000000);
    send_word(OP_QUERY,  '1, 24'h5A5A5A);
    send_word(OP_INSERT, {2'b01, 64'h5555_5555_5555_5555}, 24'h3C3C3C);
    send_word(OP_QUERY,  {2'b01, 64'h5555_5555_5555_5555}, 24'hFFFFFF);
    send_word(OP_QUERY,  {2'b00, 64'h2}, 24'h000000);
    send_word(OP_INSERT, '1, 24'h0F0F0F);
    send_word(OP_QUERY,  '0, 24'hFFFFFF);
    send_word(OP_INSERT, {2'b10, 64'hAAAA_AAAA_AAAA_AAAA}, 24'h000000);
    send_word(OP_QUERY,  {2'b11, 64'hFFFF_FFFF_FFFF_FFFF}, 24'h000000);

    // Random segments; each opens with a full drain of the engine.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      wait_drained();
      case (seg % 4)
        0: begin src_idle_pct = 0;           sink_stall_pct = 0;           end
        1: begin src_idle_pct = IdleBusyPct; sink_stall_pct = 0;           end
        2: begin src_idle_pct = 0;           sink_stall_pct = IdleBusyPct; end
        default: begin src_idle_pct = IdleBothPct; sink_stall_pct = IdleBothPct; end
      endcase
      for (int n = 0; n < SegmentWords; n++) begin
        // widen the span by one unused bit now and then
        if ((seg * SegmentWords + n) % MaskStep == 0 && span_mask != '1) begin
          do b = $urandom_range(VecW - 1); while (span_mask[b]);
          span_mask[b] = 1'b1;
        end
        send_random_word();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Drove %0d words (%0d inserts, %0d queries) and checked %0d results;",
             insert_words + query_words, insert_words, query_words, checked_count);
    $display("basis rank reached %0d, idling on neither, either and both sides.", basis_rank);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("** gf2_tagged_basis_engine: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, awaited_count);
      $display("** gf2_tagged_basis_engine: FAILED **");
    end
    $finish;
  end

endmodule
